[hdl/tac_pkg.sv]
// ----------------------------------------------------------------------------
// tac_pkg
// Shared types, constants and rounding helpers for the thrust-axis controller.
// ----------------------------------------------------------------------------
package tac_pkg;

    localparam int SQRT_STAGES = 32;
    localparam int DIV_STAGES  = 16;
    localparam int SIDE_DEPTH  = SQRT_STAGES + DIV_STAGES;
    localparam int LAW_STAGES  = 7;
    localparam int LATENCY     = 2 + SIDE_DEPTH + LAW_STAGES;
    localparam int CFG_IDX_W   = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GAIN_X  = 3'd0,
        REG_GAIN_Y  = 3'd1,
        REG_GAIN_Z  = 3'd2,
        REG_LIMIT_X = 3'd3,
        REG_LIMIT_Y = 3'd4,
        REG_LIMIT_Z = 3'd5
    } reg_idx_t;

    typedef logic signed [15:0] q14_t;
    typedef q14_t [2:0]         vec3_t;
    typedef vec3_t [2:0]        mat3_t;
    typedef logic signed [31:0] prod_t;
    typedef prod_t [9:0]        prod10_t;
    typedef logic [15:0]        gain_t;
    typedef logic [14:0]        limit_t;

    typedef struct packed {
        mat3_t rm;
        vec3_t rg;
        vec3_t t;
        logic  mode;
    } side_t;

    typedef struct packed {
        logic [35:0] rem;
        logic [31:0] root;
        logic [31:0] src;
    } sqrt_stage_t;

    typedef struct packed {
        logic [47:0] p;
        logic [32:0] d;
        logic [15:0] q;
        logic        neg;
    } div_lane_t;

    typedef struct packed {
        div_lane_t [2:0] lane;
        logic            zero;
    } div_stage_t;

    function automatic q14_t rnd_sat16(input logic signed [33:0] v);
        logic signed [33:0] x;
        logic signed [19:0] y;
        x = v + 34'sd8192;
        y = x[33:14];
        if (y > 20'sd32767)
        begin
            return 16'sh7fff;
        end
        if (y < -20'sd32768)
        begin
            return 16'sh8000;
        end
        return y[15:0];
    endfunction

    function automatic mat3_t quat_mat(input prod10_t p);
        logic signed [33:0] aa, bb, cc, dd, ab, ac, ad, bc, bd, cd;
        mat3_t m;
        aa = 34'(p[0]);
        bb = 34'(p[1]);
        cc = 34'(p[2]);
        dd = 34'(p[3]);
        ab = 34'(p[4]);
        ac = 34'(p[5]);
        ad = 34'(p[6]);
        bc = 34'(p[7]);
        bd = 34'(p[8]);
        cd = 34'(p[9]);
        m[0][0] = rnd_sat16(aa + bb - cc - dd);
        m[0][1] = rnd_sat16((bc - ad) <<< 1);
        m[0][2] = rnd_sat16((ac + bd) <<< 1);
        m[1][0] = rnd_sat16((bc + ad) <<< 1);
        m[1][1] = rnd_sat16(aa - bb + cc - dd);
        m[1][2] = rnd_sat16((cd - ab) <<< 1);
        m[2][0] = rnd_sat16((bd - ac) <<< 1);
        m[2][1] = rnd_sat16((ab + cd) <<< 1);
        m[2][2] = rnd_sat16(aa - bb - cc + dd);
        return m;
    endfunction

endpackage

[hdl/tac_qmat.sv]
// ----------------------------------------------------------------------------
// tac_qmat
// Front end: quaternion products, rotation matrices and thrust square sum.
// ----------------------------------------------------------------------------
module tac_qmat (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           valid_in,
    input  tac_pkg::q14_t  meas [4],
    input  tac_pkg::q14_t  goal [4],
    input  tac_pkg::vec3_t thrust,
    input  logic           mode,
    output logic           valid_out,
    output tac_pkg::side_t side,
    output logic [31:0]    sq
);
    import tac_pkg::*;

    logic         v1_reg, v2_reg;
    prod10_t      pm_reg, pg_reg;
    logic [30:0]  tsq_reg [3];
    vec3_t        t1_reg;
    logic         m1_reg;
    side_t        side_reg;
    logic [31:0]  sq_reg;
    mat3_t        mg;

    function automatic prod10_t quat_prods(input q14_t q [4]);
        prod10_t p;
        p[0] = q[0] * q[0];
        p[1] = q[1] * q[1];
        p[2] = q[2] * q[2];
        p[3] = q[3] * q[3];
        p[4] = q[0] * q[1];
        p[5] = q[0] * q[2];
        p[6] = q[0] * q[3];
        p[7] = q[1] * q[2];
        p[8] = q[1] * q[3];
        p[9] = q[2] * q[3];
        return p;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= valid_in;
            v2_reg <= v1_reg;
        end
    end

    always_comb
    begin
        mg = quat_mat(pg_reg);
    end

    always_ff @(posedge clk)
    begin
        pm_reg <= quat_prods(meas);
        pg_reg <= quat_prods(goal);
        for (int i = 0; i < 3; i++)
        begin
            tsq_reg[i] <= 31'(thrust[i] * thrust[i]);
        end
        t1_reg        <= thrust;
        m1_reg        <= mode;
        side_reg.rm   <= quat_mat(pm_reg);
        side_reg.rg   <= {mg[2][2], mg[1][2], mg[0][2]};
        side_reg.t    <= t1_reg;
        side_reg.mode <= m1_reg;
        sq_reg        <= 32'(tsq_reg[0]) + 32'(tsq_reg[1]) + 32'(tsq_reg[2]);
    end

    assign valid_out = v2_reg;
    assign side      = side_reg;
    assign sq        = sq_reg;

endmodule

[hdl/tac_isqrt.sv]
// ----------------------------------------------------------------------------
// tac_isqrt
// Pipelined integer square root of sq * 2^32, one result bit per stage.
// ----------------------------------------------------------------------------
module tac_isqrt (
    input  logic        clk,
    input  logic [31:0] sq,
    output logic [31:0] root
);
    import tac_pkg::*;

    sqrt_stage_t st_reg  [SQRT_STAGES];
    sqrt_stage_t st_next [SQRT_STAGES];
    sqrt_stage_t init;

    function automatic sqrt_stage_t sqrt_step(input sqrt_stage_t s);
        logic [35:0] rs;
        logic [35:0] trial;
        sqrt_stage_t o;
        rs    = {s.rem[33:0], s.src[31:30]};
        trial = {2'b00, s.root, 2'b01};
        o.src = {s.src[29:0], 2'b00};
        if (rs >= trial)
        begin
            o.rem  = rs - trial;
            o.root = {s.root[30:0], 1'b1};
        end
        else
        begin
            o.rem  = rs;
            o.root = {s.root[30:0], 1'b0};
        end
        return o;
    endfunction

    always_comb
    begin
        init.rem   = '0;
        init.root  = '0;
        init.src   = sq;
        st_next[0] = sqrt_step(init);
        for (int k = 1; k < SQRT_STAGES; k++)
        begin
            st_next[k] = sqrt_step(st_reg[k-1]);
        end
    end

    always_ff @(posedge clk)
    begin
        st_reg <= st_next;
    end

    assign root = st_reg[SQRT_STAGES-1].root;

endmodule

[hdl/tac_div.sv]
// ----------------------------------------------------------------------------
// tac_div
// Pipelined restoring divider: negated unit thrust, one quotient bit per stage.
// ----------------------------------------------------------------------------
module tac_div (
    input  logic           clk,
    input  logic [31:0]    n,
    input  tac_pkg::vec3_t t,
    output tac_pkg::vec3_t s
);
    import tac_pkg::*;

    div_stage_t st_reg  [DIV_STAGES];
    div_stage_t st_next [DIV_STAGES];
    div_stage_t init;
    div_stage_t last;

    function automatic div_stage_t div_step(input div_stage_t s_in, input int b);
        logic [47:0] ds;
        div_stage_t o;
        o = s_in;
        for (int i = 0; i < 3; i++)
        begin
            ds = {15'b0, s_in.lane[i].d} << b;
            if (s_in.lane[i].p >= ds)
            begin
                o.lane[i].p = s_in.lane[i].p - ds;
                o.lane[i].q = s_in.lane[i].q | (16'd1 << b);
            end
        end
        return o;
    endfunction

    always_comb
    begin
        init.zero = (n == 32'd0);
        for (int i = 0; i < 3; i++)
        begin
            init.lane[i].neg = t[i][15];
            init.lane[i].p   = {1'b0, (t[i][15] ? 16'(-t[i]) : 16'(t[i])), 31'b0}
                               + {16'b0, n};
            init.lane[i].d   = {n, 1'b0};
            init.lane[i].q   = '0;
        end
        st_next[0] = div_step(init, DIV_STAGES - 1);
        for (int k = 1; k < DIV_STAGES; k++)
        begin
            st_next[k] = div_step(st_reg[k-1], DIV_STAGES - 1 - k);
        end
    end

    always_ff @(posedge clk)
    begin
        st_reg <= st_next;
    end

    always_comb
    begin
        last = st_reg[DIV_STAGES-1];
        for (int i = 0; i < 3; i++)
        begin
            if (last.zero)
            begin
                s[i] = '0;
            end
            else if (last.lane[i].neg)
            begin
                s[i] = last.lane[i].q;
            end
            else
            begin
                s[i] = -last.lane[i].q;
            end
        end
    end

endmodule

[hdl/tac_law.sv]
// ----------------------------------------------------------------------------
// tac_law
// Back end: cross product error, gain scaling, body rotation and rate clamp.
// ----------------------------------------------------------------------------
module tac_law (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            valid_in,
    input  tac_pkg::side_t  side,
    input  tac_pkg::vec3_t  s_pos,
    input  tac_pkg::gain_t  gain [3],
    input  tac_pkg::limit_t limit [3],
    output logic            done,
    output tac_pkg::vec3_t  rate
);
    import tac_pkg::*;

    logic [LAW_STAGES-1:0] v_reg;
    mat3_t                 rm_reg [LAW_STAGES-2];
    vec3_t                 s_reg;
    prod_t                 cp_reg [6];
    logic signed [19:0]    e_reg  [3];
    logic signed [36:0]    gp_reg [3];
    logic signed [26:0]    w_reg  [3];
    logic signed [42:0]    fp_reg [3][3];
    vec3_t                 rate_reg;

    logic signed [32:0]    diff [3];
    logic signed [32:0]    er   [3];
    logic signed [36:0]    wr   [3];
    logic signed [44:0]    acc  [3];
    logic signed [30:0]    r    [3];
    logic signed [30:0]    lim  [3];
    vec3_t                 rate_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= {v_reg[LAW_STAGES-2:0], valid_in};
        end
    end

    always_comb
    begin
        diff[0] = 33'(cp_reg[0]) - 33'(cp_reg[1]);
        diff[1] = 33'(cp_reg[2]) - 33'(cp_reg[3]);
        diff[2] = 33'(cp_reg[4]) - 33'(cp_reg[5]);
        for (int i = 0; i < 3; i++)
        begin
            er[i]  = (diff[i] + 33'sd8192) >>> 14;
            wr[i]  = (gp_reg[i] + 37'sd512) >>> 10;
            acc[i] = 45'(fp_reg[i][0]) + 45'(fp_reg[i][1]) + 45'(fp_reg[i][2]);
            r[i]   = 31'((acc[i] + 45'sd8192) >>> 14);
            lim[i] = $signed({16'b0, limit[i]});
            if (r[i] > lim[i])
            begin
                rate_next[i] = lim[i][15:0];
            end
            else if (r[i] < -lim[i])
            begin
                rate_next[i] = 16'(-lim[i]);
            end
            else
            begin
                rate_next[i] = r[i][15:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        s_reg     <= side.mode ? s_pos : side.rg;
        rm_reg[0] <= side.rm;
        for (int k = 1; k < LAW_STAGES - 2; k++)
        begin
            rm_reg[k] <= rm_reg[k-1];
        end
        cp_reg[0] <= rm_reg[0][1][2] * s_reg[2];
        cp_reg[1] <= rm_reg[0][2][2] * s_reg[1];
        cp_reg[2] <= rm_reg[0][2][2] * s_reg[0];
        cp_reg[3] <= rm_reg[0][0][2] * s_reg[2];
        cp_reg[4] <= rm_reg[0][0][2] * s_reg[1];
        cp_reg[5] <= rm_reg[0][1][2] * s_reg[0];
        for (int i = 0; i < 3; i++)
        begin
            e_reg[i]  <= er[i][19:0];
            gp_reg[i] <= e_reg[i] * $signed({1'b0, gain[i]});
            w_reg[i]  <= wr[i][26:0];
            for (int j = 0; j < 3; j++)
            begin
                fp_reg[i][j] <= rm_reg[LAW_STAGES-3][j][i] * w_reg[j];
            end
        end
        if (v_reg[LAW_STAGES-2])
        begin
            rate_reg <= rate_next;
        end
    end

    assign done = v_reg[LAW_STAGES-1];
    assign rate = rate_reg;

endmodule

[hdl/thrust_axis_attitude_p_control.sv]
// ----------------------------------------------------------------------------
// thrust_axis_attitude_p_control
// Reduced-attitude proportional controller, fully pipelined.
// Every request passes the 32-stage square root and the 16-stage divider
// on the thrust normalisation path on its way from start to done.
// Throughput: one request per cycle; busy stays low.
// Reset clears all valid bits and sets gains to 0, rate limits to full scale.
// ----------------------------------------------------------------------------
module thrust_axis_attitude_p_control (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic signed [15:0]            meas_w,
    input  logic signed [15:0]            meas_x,
    input  logic signed [15:0]            meas_y,
    input  logic signed [15:0]            meas_z,
    input  logic signed [15:0]            goal_w,
    input  logic signed [15:0]            goal_x,
    input  logic signed [15:0]            goal_y,
    input  logic signed [15:0]            goal_z,
    input  logic signed [15:0]            thrust_x,
    input  logic signed [15:0]            thrust_y,
    input  logic signed [15:0]            thrust_z,
    input  logic                          position_mode,
    output logic                          done,
    output logic signed [15:0]            rate_x,
    output logic signed [15:0]            rate_y,
    output logic signed [15:0]            rate_z,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [tac_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0]                   cfg_data
);
    import tac_pkg::*;

    gain_t                 gain_reg  [3];
    limit_t                limit_reg [3];
    logic                  front_valid;
    side_t                 front_side;
    logic [31:0]           sq;
    logic [31:0]           root;
    vec3_t                 s_pos;
    vec3_t                 rate;
    side_t                 side_reg [SIDE_DEPTH];
    logic [SIDE_DEPTH-1:0] vld_reg;
    q14_t                  meas [4];
    q14_t                  goal [4];
    vec3_t                 thrust;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                gain_reg[i]  <= '0;
                limit_reg[i] <= '1;
            end
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (reg_idx_t'(cfg_index))
                REG_GAIN_X:  gain_reg[0]  <= cfg_data;
                REG_GAIN_Y:  gain_reg[1]  <= cfg_data;
                REG_GAIN_Z:  gain_reg[2]  <= cfg_data;
                REG_LIMIT_X: limit_reg[0] <= cfg_data[14:0];
                REG_LIMIT_Y: limit_reg[1] <= cfg_data[14:0];
                REG_LIMIT_Z: limit_reg[2] <= cfg_data[14:0];
                default:     ;
            endcase
        end
    end

    assign meas   = '{meas_w, meas_x, meas_y, meas_z};
    assign goal   = '{goal_w, goal_x, goal_y, goal_z};
    assign thrust = {thrust_z, thrust_y, thrust_x};

    tac_qmat u_qmat (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (start && !busy),
        .meas      (meas),
        .goal      (goal),
        .thrust    (thrust),
        .mode      (position_mode),
        .valid_out (front_valid),
        .side      (front_side),
        .sq        (sq)
    );

    tac_isqrt u_isqrt (
        .clk  (clk),
        .sq   (sq),
        .root (root)
    );

    tac_div u_div (
        .clk (clk),
        .n   (root),
        .t   (side_reg[SQRT_STAGES-1].t),
        .s   (s_pos)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[SIDE_DEPTH-2:0], front_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        side_reg[0] <= front_side;
        for (int k = 1; k < SIDE_DEPTH; k++)
        begin
            side_reg[k] <= side_reg[k-1];
        end
    end

    tac_law u_law (
        .clk      (clk),
        .rst_n    (rst_n),
        .valid_in (vld_reg[SIDE_DEPTH-1]),
        .side     (side_reg[SIDE_DEPTH-1]),
        .s_pos    (s_pos),
        .gain     (gain_reg),
        .limit    (limit_reg),
        .done     (done),
        .rate     (rate)
    );

    assign rate_x = rate[0];
    assign rate_y = rate[1];
    assign rate_z = rate[2];

endmodule

[hdl/tac_checker.sv]
// ----------------------------------------------------------------------------
// tac_checker
// Port-level checks on request to result timing and on readiness for the controller.
// ----------------------------------------------------------------------------
module tac_checker (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic done,
    input logic cfg_valid,
    input logic cfg_ready
);
    import tac_pkg::*;

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LATENCY done)
        else $error("request produced no result");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LATENCY))
        else $error("result without matching request");

    a_always_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (start || cfg_valid) |-> (!busy && cfg_ready))
        else $error("request refused");

endmodule

bind thrust_axis_attitude_p_control tac_checker u_tac_checker (.*);
